[rtl/rta_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the region table allocator.
// Depends on nothing; every other file of the block imports it.
package rta_pkg;

    // Table geometry and address space.
    localparam int ENTRIES   = 512;
    localparam int PAGE_BITS = 12;
    localparam int ADDR_BITS = 32;

    // Memory index width and a counter width that can also hold ENTRIES itself.
    localparam int ADR_W = $clog2(ENTRIES);
    localparam int CNT_W = ADR_W + 1;

    // Fixed widths of the item fields and of the packed stream words.
    localparam int FIELD_W     = 32;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 72;
    localparam int S_TUSER_W   = 2;
    localparam int M_TUSER_W   = 2;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef struct packed {
        addr_t start;
        addr_t size;
    } entry_t;

    localparam addr_t PAGE_BYTES = addr_t'(1) << PAGE_BITS;
    localparam cnt_t  LAST_SLOT  = cnt_t'(ENTRIES - 1);

    // Largest page count whose byte size still fits in the address space.
    localparam logic [ADDR_BITS:0] Q_MAX =
        ((ADDR_BITS + 1)'(1) << (ADDR_BITS - PAGE_BITS)) - (ADDR_BITS + 1)'(1);

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CHECK   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_SCAN,
        ST_SHIFT,
        ST_RESULT
    } state_t;

    // Round a byte count up to whole pages, at least one page, saturating to
    // the largest whole-page size that fits.
    function automatic addr_t round_pages(addr_t sz);
        logic [ADDR_BITS:0] q;
        q = (ADDR_BITS + 1)'(sz >> PAGE_BITS) + (ADDR_BITS + 1)'(|sz[PAGE_BITS-1:0]);
        if (sz <= PAGE_BYTES) begin
            return PAGE_BYTES;
        end
        if (q > Q_MAX) begin
            q = Q_MAX;
        end
        return addr_t'(q << PAGE_BITS);
    endfunction

    // True when a lies in [start, start + size], both ends included.
    function automatic logic in_region(addr_t a, addr_t start, addr_t size);
        addr_t off;
        off = a - start;
        return (a >= start) && (off <= size);
    endfunction

endpackage

[rtl/region_table_allocator.sv]
`timescale 1ns / 1ps
// Top level of the region table allocator: control sequencer, region table memory
// and result register. Depends on rta_pkg.
//
// The block keeps a table of regions (start, size) for one pool. Entry 0 is the
// pool's own page at the pool base and lives in registers; entries 1 up to the used
// count live in a single synchronous memory with a registered read.
// Items arrive on the s_ stream (mode in s_tuser, sizes and addresses in s_tdata)
// and every item gives exactly one result on the m_ stream. Items are handled one
// at a time: s_tready is high only while the sequencer is idle, and a finished
// result waits in its own output register, so the next item can be taken while
// the previous result is still held by a stalled consumer. An item that settles
// at once (a refused allocate, a release on an empty table, a check that hits the
// base page or finds the table empty, and the unused mode) goes straight from the
// idle state to the result state, and an allocate passes through the allocate
// state first. A check or release walks the table through the memory's single
// read port at one entry per cycle: a check that hits entry i stops there; a
// check or release that finds nothing, or a release of the last used entry, reads
// all n used entries; any other release also copies every later entry down by
// one, overlapped with its reads. The longest item is a release with 511 used
// entries. s_tready rises again at the same edge that loads the result register;
// a stalled consumer holds the sequencer only when the next result is ready before
// the previous one has been taken. Entries beyond the used count are never read,
// so no clearing pass is needed after reset. The user must write the pool base on
// the cfg_ port only while the block is idle; the block itself does not enforce
// this. A write moves entry 0 at once.
module region_table_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write: pool base.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rta_pkg::FIELD_W-1:0]       cfg_data,
    // Input items.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rta_pkg::S_TDATA_W-1:0]     s_tdata,   // request_size[31:0], address[63:32]
    input  logic [rta_pkg::S_TUSER_W-1:0]     s_tuser,   // mode[1:0]
    // Result items.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rta_pkg::M_TDATA_W-1:0]     m_tdata,   // region_start[31:0],
                                                         // region_size[63:32],
                                                         // legitimate[64], zero[71:65]
    output logic [rta_pkg::M_TUSER_W-1:0]     m_tuser    // status[1:0]
);
    import rta_pkg::*;

    // Region table memory for entries 1 and up.
    entry_t mem [ENTRIES];
    entry_t rdata_reg;
    logic   mem_re;
    logic   mem_we;
    logic [ADR_W-1:0] mem_raddr;
    logic [ADR_W-1:0] mem_waddr;
    entry_t mem_wdata;

    // Control state.
    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    addr_t  base_reg, base_next;
    cnt_t   rd_idx_reg, rd_idx_next;
    logic   pend_reg, pend_next;
    cnt_t   pend_idx_reg, pend_idx_next;
    logic   out_valid_reg, out_valid_next;

    // Item and result payload.
    mode_t   mode_reg, mode_next;
    addr_t   addr_reg, addr_next;
    addr_t   size_reg, size_next;
    addr_t   res_start_reg, res_start_next;
    addr_t   res_size_reg, res_size_next;
    logic    res_legit_reg, res_legit_next;
    status_t res_status_reg, res_status_next;
    addr_t   out_start_reg, out_start_next;
    addr_t   out_size_reg, out_size_next;
    logic    out_legit_reg, out_legit_next;
    status_t out_status_reg, out_status_next;

    // Decoded conditions shared by the next-state and datapath logic.
    logic   s_accept;
    mode_t  mode_in;
    addr_t  addr_in;
    logic   table_full;
    logic   count_zero;
    logic   legit_now;
    logic   scan_match;
    logic   scan_last;
    logic   out_free;
    entry_t prev_entry;
    addr_t  new_start;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign mode_in   = mode_t'(s_tuser[1:0]);
    assign addr_in   = addr_t'(s_tdata[2*FIELD_W-1:FIELD_W]);

    assign table_full = (count_reg >= LAST_SLOT);
    assign count_zero = (count_reg == '0);

    // A check settles at once when it hits the base address or the base page.
    assign legit_now = (addr_in == base_reg) || in_region(addr_in, base_reg, PAGE_BYTES);

    // During a walk, rdata_reg holds the entry at pend_idx_reg when pend_reg is set.
    assign scan_match = pend_reg &&
                        ((mode_reg == MODE_RELEASE) ? (rdata_reg.start == addr_reg)
                                                    : in_region(addr_reg, rdata_reg.start,
                                                                rdata_reg.size));
    assign scan_last  = pend_reg && (pend_idx_reg == count_reg);

    assign out_free = !out_valid_reg || m_tready;

    // A new region follows the last used entry, or the base page in an empty table.
    assign prev_entry = count_zero ? entry_t'{start: base_reg, size: PAGE_BYTES} : rdata_reg;
    assign new_start  = prev_entry.start + prev_entry.size;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (mode_in)
                        MODE_ALLOC: begin
                            state_next = table_full ? ST_RESULT : ST_ALLOC;
                        end
                        MODE_RELEASE: begin
                            state_next = count_zero ? ST_RESULT : ST_SCAN;
                        end
                        MODE_CHECK: begin
                            state_next = (legit_now || count_zero) ? ST_RESULT : ST_SCAN;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                state_next = ST_RESULT;
            end
            ST_SCAN: begin
                if (scan_match && (mode_reg == MODE_RELEASE) && !scan_last) begin
                    state_next = ST_SHIFT;
                end else if (scan_match || scan_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_SHIFT: begin
                if (scan_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory control and result register.
    always_comb begin
        count_next      = count_reg;
        base_next       = base_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        size_next       = size_reg;
        res_start_next  = res_start_reg;
        res_size_next   = res_size_reg;
        res_legit_next  = res_legit_reg;
        res_status_next = res_status_reg;
        out_start_next  = out_start_reg;
        out_size_next   = out_size_reg;
        out_legit_next  = out_legit_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_raddr       = '0;
        mem_waddr       = '0;
        mem_wdata       = '0;

        if (cfg_valid && cfg_ready) begin
            base_next = addr_t'(cfg_data);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    mode_next       = mode_in;
                    addr_next       = addr_in;
                    size_next       = round_pages(addr_t'(s_tdata[FIELD_W-1:0]));
                    res_start_next  = '0;
                    res_size_next   = '0;
                    res_legit_next  = 1'b0;
                    res_status_next = STATUS_OK;
                    rd_idx_next     = cnt_t'(1);
                    unique case (mode_in)
                        MODE_ALLOC: begin
                            if (table_full) begin
                                res_status_next = STATUS_FULL;
                            end else begin
                                // Fetch the last used entry; its end is the new start.
                                mem_re    = 1'b1;
                                mem_raddr = count_reg[ADR_W-1:0];
                            end
                        end
                        MODE_RELEASE: begin
                            if (count_zero) begin
                                res_status_next = STATUS_NOT_FOUND;
                            end
                        end
                        MODE_CHECK: begin
                            res_legit_next = legit_now;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                mem_we          = 1'b1;
                mem_waddr       = ADR_W'(count_reg + cnt_t'(1));
                mem_wdata       = '{start: new_start, size: size_reg};
                count_next      = count_reg + cnt_t'(1);
                res_start_next  = new_start;
                res_size_next   = size_reg;
            end
            ST_SCAN: begin
                // One read issued per cycle; compare the one that came back.
                if (rd_idx_reg <= count_reg) begin
                    mem_re        = 1'b1;
                    mem_raddr     = rd_idx_reg[ADR_W-1:0];
                    rd_idx_next   = rd_idx_reg + cnt_t'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                end
                if (scan_match) begin
                    if (mode_reg == MODE_RELEASE) begin
                        res_start_next = rdata_reg.start;
                        res_size_next  = rdata_reg.size;
                        if (scan_last) begin
                            count_next = count_reg - cnt_t'(1);
                        end else begin
                            // Restart reads just above the hit for the copy-down.
                            rd_idx_next = pend_idx_reg + cnt_t'(1);
                            pend_next   = 1'b0;
                        end
                    end else begin
                        res_legit_next = 1'b1;
                    end
                end else if (scan_last && (mode_reg == MODE_RELEASE)) begin
                    res_status_next = STATUS_NOT_FOUND;
                end
            end
            ST_SHIFT: begin
                if (rd_idx_reg <= count_reg) begin
                    mem_re        = 1'b1;
                    mem_raddr     = rd_idx_reg[ADR_W-1:0];
                    rd_idx_next   = rd_idx_reg + cnt_t'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                end
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = ADR_W'(pend_idx_reg - cnt_t'(1));
                    mem_wdata = rdata_reg;
                end
                if (scan_last) begin
                    count_next = count_reg - cnt_t'(1);
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_start_next  = res_start_reg;
                    out_size_next   = res_size_reg;
                    out_legit_next  = res_legit_reg;
                    out_status_next = res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            base_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        pend_idx_reg   <= pend_idx_next;
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        size_reg       <= size_next;
        res_start_reg  <= res_start_next;
        res_size_reg   <= res_size_next;
        res_legit_reg  <= res_legit_next;
        res_status_reg <= res_status_next;
        out_start_reg  <= out_start_next;
        out_size_reg   <= out_size_next;
        out_legit_reg  <= out_legit_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 2*FIELD_W - 1)'(0), out_legit_reg,
                       FIELD_W'(out_size_reg), FIELD_W'(out_start_reg)};
    assign m_tuser  = out_status_reg;

endmodule

[rtl/region_table_allocator_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the region table allocator, bound to its top level.
// Depends on rta_pkg and region_table_allocator.
module region_table_allocator_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [rta_pkg::FIELD_W-1:0]       cfg_data,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [rta_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic [rta_pkg::S_TUSER_W-1:0]     s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rta_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [rta_pkg::M_TUSER_W-1:0]     m_tuser
);
    import rta_pkg::*;

    // A result that is not taken stays in place.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item still in work");

    // Errors carry no region and no check flag.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STATUS_OK)) |->
        ((m_tdata[2*FIELD_W-1:0] == '0) && !m_tdata[2*FIELD_W]))
        else $error("error result carries data");

    // A positive check reports no region.
    a_check_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2*FIELD_W]) |->
        ((m_tdata[2*FIELD_W-1:0] == '0) && (m_tuser == STATUS_OK)))
        else $error("check result carries a region");

endmodule

bind region_table_allocator region_table_allocator_checker u_checker (.*);

[verif/tb_region_table_allocator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for region_table_allocator: directed rows, then random
// phases that fill and overflow the region table and then release from it. Depends on rta_pkg and the RTL.
module tb_region_table_allocator;
    import rta_pkg::*;

    localparam addr_t ONE_PAGE = addr_t'(1) << PAGE_BITS;
    localparam logic [ADDR_BITS:0] MAX_PAGES =
        (ADDR_BITS + 1)'((64'd1 << (ADDR_BITS - PAGE_BITS)) - 64'd1);
    // The mode code that the block must ignore.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 600;

    typedef struct packed {
        addr_t   start;
        addr_t   size;
        logic    legit;
        status_t status;
    } region_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_BASE
    } row_kind_t;

    // One directed row: an item, or a new pool base (held in adr).
    typedef struct packed {
        row_kind_t      kind;
        logic [1:0]     mode;
        addr_t          req;
        addr_t          adr;
        logic           typed;
        region_result_t want;
    } dir_row_t;

    localparam region_result_t NO_RESULT = '0;
    localparam int NUM_DIR = 26;
    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        // Fresh table: the base itself is legitimate, nothing can be released.
        '{ROW_ITEM, MODE_CHECK,   32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b1, STATUS_OK}},
        '{ROW_ITEM, MODE_RELEASE, 32'h0, 32'h0, 1'b1,
          '{32'h0, 32'h0, 1'b0, STATUS_NOT_FOUND}},
        // Zero bytes and exactly one page both round to one page.
        '{ROW_ITEM, MODE_ALLOC, 32'h0, 32'h0, 1'b1,
          '{32'h1000, 32'h1000, 1'b0, STATUS_OK}},
        '{ROW_ITEM, MODE_ALLOC, 32'h1000, 32'hFFFF_FFFF, 1'b1,
          '{32'h2000, 32'h1000, 1'b0, STATUS_OK}},
        '{ROW_ITEM, MODE_ALLOC, 32'h1001, 32'h0, 1'b0, NO_RESULT},
        // The largest request saturates to the largest whole-page size.
        '{ROW_ITEM, MODE_ALLOC, 32'hFFFF_FFFF, 32'h0, 1'b1,
          '{32'h5000, 32'hFFFF_F000, 1'b0, STATUS_OK}},
        // The next start wraps around the address space.
        '{ROW_ITEM, MODE_ALLOC, 32'h1, 32'h0, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_CHECK, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_CHECK, 32'h0, 32'h5000, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_CHECK, 32'h0, 32'h3000, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_RELEASE, 32'h0, 32'h2000, 1'b1,
          '{32'h2000, 32'h1000, 1'b0, STATUS_OK}},
        '{ROW_ITEM, MODE_RELEASE, 32'h0, 32'h2000, 1'b1,
          '{32'h0, 32'h0, 1'b0, STATUS_NOT_FOUND}},
        '{ROW_ITEM, MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_RESULT},
        // Moving the base moves entry 0 only.
        '{ROW_BASE, MODE_ALLOC, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_CHECK, 32'h0, 32'hFFFF_FFFF, 1'b1,
          '{32'h0, 32'h0, 1'b1, STATUS_OK}},
        '{ROW_ITEM, MODE_ALLOC, 32'h2000, 32'h0, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_CHECK, 32'h0, 32'h0, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_RELEASE, 32'h0, 32'h1000, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_UNUSED, 32'h0, 32'h0, 1'b1, NO_RESULT},
        '{ROW_BASE, MODE_ALLOC, 32'h0, 32'h1234_5000, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_CHECK, 32'h0, 32'h1234_6000, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_CHECK, 32'h0, 32'h1234_6001, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_RELEASE, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_ALLOC, 32'h7FFF_FFFF, 32'h0, 1'b0, NO_RESULT},
        '{ROW_BASE, MODE_ALLOC, 32'h0, 32'h0, 1'b0, NO_RESULT},
        '{ROW_ITEM, MODE_CHECK, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b1, STATUS_OK}}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [FIELD_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // request_size[31:0], address[63:32]
    logic [S_TUSER_W-1:0] s_tuser;   // mode[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // region_start[31:0], region_size[63:32], legitimate[64]
    logic [M_TUSER_W-1:0] m_tuser;   // status[1:0]

    // Shadow copy of the region table and the pool base.
    addr_t       base_reg;
    addr_t       tbl_start [ENTRIES];
    addr_t       tbl_size  [ENTRIES];
    int unsigned n_used;

    region_result_t pending_results [$];
    int unsigned    err_count;
    int unsigned    n_items, n_results, n_allocs, n_full, n_missing, n_legit;
    logic           quiet;

    region_table_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle cycles before the next item on either side; now and then a stretch without any.
    function automatic int pick_gap();
        if ($urandom_range(0, 39) == 0) begin
            quiet = !quiet;
        end
        return quiet ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic addr_t pages_for(addr_t req);
        logic [ADDR_BITS:0] pages;
        if (req <= ONE_PAGE) begin
            return ONE_PAGE;
        end
        pages = {1'b0, req} >> PAGE_BITS;
        if (req[PAGE_BITS-1:0] != '0) begin
            pages = pages + 1'b1;
        end
        if (pages > MAX_PAGES) begin
            pages = MAX_PAGES;
        end
        return addr_t'(pages << PAGE_BITS);
    endfunction

    // Applies one item to the shadow table and returns the result it must give.
    function automatic region_result_t table_step(logic [1:0] mode, addr_t req, addr_t adr);
        region_result_t r;
        int unsigned    hit;
        r = '0;
        hit = 0;
        tbl_start[0] = base_reg;
        tbl_size[0]  = ONE_PAGE;
        case (mode)
            MODE_ALLOC: begin
                if (n_used >= ENTRIES - 1) begin
                    r.status = STATUS_FULL;
                end else begin
                    n_used++;
                    tbl_start[n_used] = tbl_start[n_used-1] + tbl_size[n_used-1];
                    tbl_size[n_used]  = pages_for(req);
                    r.start = tbl_start[n_used];
                    r.size  = tbl_size[n_used];
                end
            end
            MODE_RELEASE: begin
                // Only the lowest matching entry goes; entry 0 never does.
                for (int unsigned i = 1; i <= n_used && hit == 0; i++) begin
                    if (tbl_start[i] == adr) begin
                        hit = i;
                    end
                end
                if (hit == 0) begin
                    r.status = STATUS_NOT_FOUND;
                end else begin
                    r.start = tbl_start[hit];
                    r.size  = tbl_size[hit];
                    for (int unsigned i = hit; i < n_used; i++) begin
                        tbl_start[i] = tbl_start[i+1];
                        tbl_size[i]  = tbl_size[i+1];
                    end
                    tbl_start[n_used] = '0;
                    tbl_size[n_used]  = '0;
                    n_used--;
                end
            end
            MODE_CHECK: begin
                if (adr == base_reg) begin
                    r.legit = 1'b1;
                end
                for (int unsigned i = 0; i <= n_used && !r.legit; i++) begin
                    if (adr >= tbl_start[i] && (adr - tbl_start[i]) <= tbl_size[i]) begin
                        r.legit = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Offers one item, waits for it to be taken and files its expected result.
    task automatic apply_item(input logic [1:0] mode, input addr_t req, input addr_t adr,
                              input logic typed, input region_result_t want);
        int             gap;
        region_result_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {adr, req};
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = table_step(mode, req, adr);
        pending_results.push_back(typed ? want : predicted);
        n_items++;
        if (mode == MODE_ALLOC && predicted.status == STATUS_OK) n_allocs++;
        if (predicted.status == STATUS_FULL) n_full++;
        if (predicted.status == STATUS_NOT_FOUND) n_missing++;
        if (predicted.legit) n_legit++;
    endtask

    // The pool base changes only once every pending result has come back.
    task automatic set_base(input addr_t value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid    <= 1'b0;
        base_reg     = value;
        tbl_start[0] = value;
    endtask

    // Random item with the given percentages of allocate, release and check; the
    // remainder uses the unused mode. Releases mostly name a live region start and
    // checks mostly probe at or around region edges.
    task automatic random_item(input int alloc_w, input int release_w, input int check_w);
        int          pick;
        int unsigned k;
        logic [1:0]  mode;
        addr_t       req;
        addr_t       adr;
        pick = $urandom_range(0, 99);
        if (pick < alloc_w) mode = MODE_ALLOC;
        else if (pick < alloc_w + release_w) mode = MODE_RELEASE;
        else if (pick < alloc_w + release_w + check_w) mode = MODE_CHECK;
        else mode = MODE_UNUSED;
        req = $urandom();
        adr = $urandom();
        case (mode)
            MODE_ALLOC: begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                    end
                    2, 3, 4: req = ($urandom_range(1, 16) << PAGE_BITS) + $urandom_range(0, 2) - 1;
                    default: req = $urandom_range(0, 32'h8000);
                endcase
            end
            MODE_RELEASE: begin
                if (n_used > 0 && $urandom_range(0, 3) != 0) begin
                    adr = tbl_start[$urandom_range(1, n_used)];
                end else if ($urandom_range(0, 1) == 0) begin
                    adr = base_reg;
                end
            end
            MODE_CHECK: begin
                k = $urandom_range(0, n_used);
                case ($urandom_range(0, 4))
                    0: begin
                    end
                    1: adr = tbl_start[k];
                    2: adr = tbl_start[k] + tbl_size[k];
                    3: adr = tbl_start[k] + tbl_size[k] + 1;
                    default: adr = tbl_start[k] + $urandom_range(0, tbl_size[k]);
                endcase
            end
            default: begin
            end
        endcase
        apply_item(mode, req, adr, 1'b0, NO_RESULT);
    endtask

    // Result side: random stalls, then every result against the oldest expectation.
    initial begin : result_check
        int             gap;
        region_result_t want;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (pending_results.size() == 0) begin
                $error("result with no item pending: tdata=%h tuser=%h", m_tdata, m_tuser);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (m_tdata[31:0] !== want.start) begin
                    $error("region_start: expected %h, got %h", want.start, m_tdata[31:0]);
                    err_count++;
                end
                if (m_tdata[63:32] !== want.size) begin
                    $error("region_size: expected %h, got %h", want.size, m_tdata[63:32]);
                    err_count++;
                end
                if (m_tdata[64] !== want.legit) begin
                    $error("legitimate: expected %0d, got %0d", want.legit, m_tdata[64]);
                    err_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        quiet     = 1'b0;
        err_count = 0;
        n_items = 0; n_results = 0; n_allocs = 0; n_full = 0; n_missing = 0; n_legit = 0;
        base_reg = '0;
        n_used   = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_start[i] = '0;
            tbl_size[i]  = '0;
        end
        tbl_size[0] = ONE_PAGE;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NUM_DIR; r++) begin
            if (DIR_ROWS[r].kind == ROW_BASE) begin
                set_base(DIR_ROWS[r].adr);
            end else begin
                apply_item(DIR_ROWS[r].mode, DIR_ROWS[r].req, DIR_ROWS[r].adr,
                           DIR_ROWS[r].typed, DIR_ROWS[r].want);
            end
        end

        // Mixed traffic on a small table under a random base.
        set_base($urandom());
        repeat (24) random_item(45, 25, 25);

        // Fill the table to the last entry with allocations, then keep pushing so
        // that allocations are refused and releases reopen single slots.
        set_base(32'hFFFF_F000);
        while (n_used < ENTRIES - 1) random_item(100, 0, 0);
        repeat (12) random_item(55, 20, 20);

        // Release-heavy traffic under a new base, then mixed traffic at base zero.
        set_base($urandom() & 32'hFFFF_F000);
        repeat (12) random_item(15, 50, 30);
        set_base(32'h0);
        repeat (12) random_item(35, 30, 30);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d items and %0d checked results, %0d regions allocated.",
                 n_items, n_results, n_allocs);
        $display("Refused allocations %0d, unmatched releases %0d, legitimate probes %0d.",
                 n_full, n_missing, n_legit);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #15_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
rtl/rta_pkg.sv
rtl/region_table_allocator.sv
rtl/region_table_allocator_checker.sv
verif/tb_region_table_allocator.sv
